>>> rtl/core/svt_pkg.sv
// Shared definitions for the snapshot version tracker: field widths, request
// and status codes, and the command/status bundles between controller and datapath.
// No dependencies.
package svt_pkg;

	localparam int DEF_MAX_SLOTS    = 64;
	localparam int DEF_VERSION_BITS = 64;

	localparam int CFG_W     = 7;
	localparam int OP_W      = 3;
	localparam int SLOT_ID_W = 6;
	localparam int FIELD_W   = 64;
	localparam int STATUS_W  = 3;

	localparam logic [OP_W-1:0] OP_REGISTER   = 3'd0;
	localparam logic [OP_W-1:0] OP_DEREGISTER = 3'd1;
	localparam logic [OP_W-1:0] OP_BEGIN_READ = 3'd2;
	localparam logic [OP_W-1:0] OP_COMMIT     = 3'd3;
	localparam logic [OP_W-1:0] OP_COMPLETE   = 3'd4;
	localparam logic [OP_W-1:0] OP_QUERY_MIN  = 3'd5;

	localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
	localparam logic [STATUS_W-1:0] ST_SLOT_IN_USE = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_REG     = 3'd2;
	localparam logic [STATUS_W-1:0] ST_ACTIVE_TXN  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_ALREADY_OPEN = 3'd4;
	localparam logic [STATUS_W-1:0] ST_NOT_OWNER   = 3'd5;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic scan_start;
		logic scan_step;
		logic exec;
		logic clr_step;
		logic accept_off;
	} svt_cmd_t;

	// Status from the datapath back to the controller.
	typedef struct packed {
		logic cfg_take;
		logic clr_last;
		logic scan_done;
		logic in_vld;
		logic in_query;
		logic out_free;
	} svt_sts_t;

endpackage

>>> rtl/core/snapshot_version_tracker_core.sv
// Top level of the snapshot version tracker: stream ports and configuration write port.
// Depends on svt_pkg, svt_ctrl and svt_datapath.

// The tracker hands out versions from a global counter and keeps one slot table entry
// per participant (an in-use flag and its active snapshot version), held in a single
// RAM with one write and one registered read port. Each item on the slave side is one
// request and yields exactly one item on the master side. Requests that touch one slot
// (register, deregister, begin read, commit, complete, undefined ops) read the slot entry
// in the idle state and decide, write back and load the result in the execute state. A
// minimum query walks the table through the RAM read port, one entry per cycle, and then
// loads its result. After reset, and after every slot_count write that is taken (no slot
// registered), a clearing pass writes every entry, during which s_tready is low; writes
// to slot_count are still taken. An input register and an output register part the two
// sides, so the next item is taken while a result waits. Results keep request order.
module snapshot_version_tracker_core #(
	parameter int MAX_SLOTS    = svt_pkg::DEF_MAX_SLOTS,
	parameter int VERSION_BITS = svt_pkg::DEF_VERSION_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// Configuration: slot_count.
	input  logic                      cfg_wr_en,
	input  logic [svt_pkg::CFG_W-1:0] cfg_wr_data,
	// Request stream.
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// From bit 0: slot_id[5:0], txn_read_version[69:6], txn_commit_version[133:70],
	// zero padding [135:134].
	input  logic [135:0]              s_tdata,
	// From bit 0: op[2:0].
	input  logic [2:0]                s_tuser,
	// Result stream.
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// From bit 0: timestamp[63:0], oldest_version[127:64].
	output logic [127:0]              m_tdata,
	// From bit 0: status[2:0].
	output logic [2:0]                m_tuser
);

	svt_pkg::svt_cmd_t cmd;
	svt_pkg::svt_sts_t sts;

	logic [svt_pkg::FIELD_W-1:0] res_ts;
	logic [svt_pkg::FIELD_W-1:0] res_mv;

	svt_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.sts   (sts),
		.cmd   (cmd)
	);

	svt_datapath #(
		.MAX_SLOTS   (MAX_SLOTS),
		.VERSION_BITS(VERSION_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_op      (s_tuser),
		.in_slot    (s_tdata[5:0]),
		.in_rv      (s_tdata[69:6]),
		.in_cv      (s_tdata[133:70]),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_status (m_tuser),
		.out_ts     (res_ts),
		.out_mv     (res_mv)
	);

	// The padding bits of s_tdata carry nothing.
	assign m_tdata = {res_mv, res_ts};

endmodule

>>> rtl/core/svt_ram.sv
// Generic simple dual-port RAM: one write port and one read port with registered read data.
// No dependencies.
module svt_ram #(
	parameter int WIDTH = 65,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/core/svt_datapath.sv
// Datapath of the snapshot version tracker: input and output registers, slot table RAM,
// version counter, slot count, scan and clear index. Depends on svt_pkg and svt_ram.
module svt_datapath #(
	parameter int MAX_SLOTS    = svt_pkg::DEF_MAX_SLOTS,
	parameter int VERSION_BITS = svt_pkg::DEF_VERSION_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  svt_pkg::svt_cmd_t             cmd,
	output svt_pkg::svt_sts_t             sts,
	input  logic                          cfg_wr_en,
	input  logic [svt_pkg::CFG_W-1:0]     cfg_wr_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [svt_pkg::OP_W-1:0]      in_op,
	input  logic [svt_pkg::SLOT_ID_W-1:0] in_slot,
	input  logic [svt_pkg::FIELD_W-1:0]   in_rv,
	input  logic [svt_pkg::FIELD_W-1:0]   in_cv,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [svt_pkg::STATUS_W-1:0]  out_status,
	output logic [svt_pkg::FIELD_W-1:0]   out_ts,
	output logic [svt_pkg::FIELD_W-1:0]   out_mv
);

	localparam int SLOT_W  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int CNT_W   = $clog2(MAX_SLOTS + 1);
	localparam int CMP_W   = (CNT_W > svt_pkg::CFG_W) ? CNT_W : svt_pkg::CFG_W;
	localparam int ENT_W   = VERSION_BITS + 1;
	localparam int RST_CNT = (MAX_SLOTS < 64) ? MAX_SLOTS : 64;
	localparam logic [VERSION_BITS-1:0] NONE = '1;

	// Input holding register.
	logic                          in_vld_q;
	logic [svt_pkg::OP_W-1:0]      op_q;
	logic [svt_pkg::SLOT_ID_W-1:0] slot_q;
	logic [VERSION_BITS-1:0]       rv_q;
	logic [VERSION_BITS-1:0]       cv_q;

	logic [VERSION_BITS-1:0] ctr_q;
	logic [CNT_W-1:0]        slot_count_q;
	logic [CNT_W-1:0]        users_q;
	logic [CNT_W-1:0]        idx_q;
	logic                    pend_q;
	logic [VERSION_BITS-1:0] min_q;

	logic                     out_vld_q;
	logic [svt_pkg::STATUS_W-1:0] out_status_q;
	logic [VERSION_BITS-1:0]  out_ts_q;
	logic [VERSION_BITS-1:0]  out_mv_q;

	logic              ram_we;
	logic [SLOT_W-1:0] ram_waddr;
	logic [ENT_W-1:0]  ram_wdata;
	logic [SLOT_W-1:0] ram_raddr;
	logic [ENT_W-1:0]  ram_rdata;

	logic                    ent_use;
	logic [VERSION_BITS-1:0] ent_ver;
	logic [SLOT_W-1:0]       slot_idx;
	logic                    range_fail;
	logic                    cfg_take;
	logic [CNT_W-1:0]        cfg_count;
	logic                    out_free;
	logic                    scan_more;

	// Execute-stage decisions.
	logic [svt_pkg::STATUS_W-1:0] x_status;
	logic [VERSION_BITS-1:0]      x_ts;
	logic                         x_wr;
	logic [ENT_W-1:0]             x_wdata;
	logic                         x_draw;
	logic                         x_inc;
	logic                         x_dec;

	assign ent_use    = ram_rdata[VERSION_BITS];
	assign ent_ver    = ram_rdata[VERSION_BITS-1:0];
	assign slot_idx   = SLOT_W'(slot_q);
	assign range_fail = (op_q <= svt_pkg::OP_COMPLETE) &&
	                    (CMP_W'(slot_q) >= CMP_W'(slot_count_q));
	assign cfg_take   = cfg_wr_en && (users_q == '0);
	assign out_free   = !out_vld_q || out_ready;
	assign scan_more  = idx_q < slot_count_q;

	always_comb begin
		if (cfg_wr_data == '0) begin
			cfg_count = CNT_W'(1);
		end else if (CMP_W'(cfg_wr_data) > CMP_W'(MAX_SLOTS)) begin
			cfg_count = CNT_W'(MAX_SLOTS);
		end else begin
			cfg_count = CNT_W'(cfg_wr_data);
		end
	end

	always_comb begin
		x_status = svt_pkg::ST_OK;
		x_ts     = '0;
		x_wr     = 1'b0;
		x_wdata  = ram_rdata;
		x_draw   = 1'b0;
		x_inc    = 1'b0;
		x_dec    = 1'b0;
		if (range_fail) begin
			x_status = svt_pkg::ST_NOT_REG;
		end else begin
			unique case (op_q)
				svt_pkg::OP_REGISTER: begin
					if (ent_use) begin
						x_status = svt_pkg::ST_SLOT_IN_USE;
					end else begin
						x_wr    = 1'b1;
						x_wdata = {1'b1, ent_ver};
						x_inc   = 1'b1;
					end
				end
				svt_pkg::OP_DEREGISTER: begin
					if (!ent_use) begin
						x_status = svt_pkg::ST_NOT_REG;
					end else if (ent_ver != NONE) begin
						x_status = svt_pkg::ST_ACTIVE_TXN;
					end else begin
						x_wr    = 1'b1;
						x_wdata = {1'b0, ent_ver};
						x_dec   = 1'b1;
					end
				end
				svt_pkg::OP_BEGIN_READ: begin
					if (ent_ver != NONE) begin
						x_status = svt_pkg::ST_ALREADY_OPEN;
					end else begin
						x_ts    = ctr_q;
						x_draw  = 1'b1;
						x_wr    = 1'b1;
						x_wdata = {ent_use, ctr_q};
					end
				end
				svt_pkg::OP_COMMIT: begin
					x_ts    = ctr_q;
					x_draw  = 1'b1;
					x_wr    = (ent_ver == NONE);
					x_wdata = {ent_use, ctr_q};
				end
				svt_pkg::OP_COMPLETE: begin
					if (rv_q != ent_ver && cv_q != ent_ver) begin
						x_status = svt_pkg::ST_NOT_OWNER;
					end else begin
						x_wr    = 1'b1;
						x_wdata = {ent_use, NONE};
					end
				end
				default: begin
				end
			endcase
		end
	end

	// RAM port selection.
	always_comb begin
		if (cmd.scan_step) begin
			ram_raddr = idx_q[SLOT_W-1:0];
		end else if (cmd.scan_start) begin
			ram_raddr = '0;
		end else begin
			ram_raddr = slot_idx;
		end
		if (cmd.clr_step) begin
			ram_we    = 1'b1;
			ram_waddr = idx_q[SLOT_W-1:0];
			ram_wdata = {1'b0, NONE};
		end else begin
			ram_we    = cmd.exec && x_wr;
			ram_waddr = slot_idx;
			ram_wdata = x_wdata;
		end
	end

	svt_ram #(
		.WIDTH(ENT_W),
		.DEPTH(MAX_SLOTS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign in_ready = !cmd.accept_off && (!in_vld_q || cmd.exec);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_vld_q     <= 1'b0;
			out_vld_q    <= 1'b0;
			ctr_q        <= '0;
			slot_count_q <= CNT_W'(RST_CNT);
			users_q      <= '0;
			idx_q        <= '0;
			pend_q       <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				in_vld_q <= 1'b1;
			end else if (cmd.exec) begin
				in_vld_q <= 1'b0;
			end

			if (cmd.exec) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end

			if (cmd.exec && x_draw) begin
				ctr_q <= ctr_q + 1'b1;
			end
			if (cmd.exec && x_inc) begin
				users_q <= users_q + 1'b1;
			end else if (cmd.exec && x_dec) begin
				users_q <= users_q - 1'b1;
			end

			if (cfg_take) begin
				slot_count_q <= cfg_count;
				idx_q        <= '0;
			end else if (cmd.clr_step) begin
				idx_q <= idx_q + 1'b1;
			end else if (cmd.scan_start) begin
				idx_q  <= CNT_W'(1);
				pend_q <= 1'b1;
			end else if (cmd.scan_step) begin
				pend_q <= scan_more;
				if (scan_more) begin
					idx_q <= idx_q + 1'b1;
				end
			end else if (cmd.exec) begin
				idx_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q   <= in_op;
			slot_q <= in_slot;
			rv_q   <= VERSION_BITS'(in_rv);
			cv_q   <= VERSION_BITS'(in_cv);
		end
		if (cmd.scan_start) begin
			min_q <= ctr_q;
		end else if (cmd.scan_step && pend_q && ent_ver < min_q) begin
			min_q <= ent_ver;
		end
		if (cmd.exec) begin
			out_status_q <= x_status;
			out_ts_q     <= x_ts;
			out_mv_q     <= (!range_fail && op_q == svt_pkg::OP_QUERY_MIN) ? min_q : '0;
		end
	end

	assign out_valid  = out_vld_q;
	assign out_status = out_status_q;
	assign out_ts     = svt_pkg::FIELD_W'(out_ts_q);
	assign out_mv     = svt_pkg::FIELD_W'(out_mv_q);

	assign sts.cfg_take  = cfg_take;
	assign sts.clr_last  = (idx_q == CNT_W'(MAX_SLOTS - 1));
	assign sts.scan_done = !pend_q;
	assign sts.in_vld    = in_vld_q;
	assign sts.in_query  = (op_q == svt_pkg::OP_QUERY_MIN);
	assign sts.out_free  = out_free;

endmodule

>>> rtl/core/svt_ctrl.sv
// Controller state machine of the snapshot version tracker: sequences the clearing
// pass, single-slot requests and the minimum scan. Depends on svt_pkg.
module svt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  svt_pkg::svt_sts_t sts,
	output svt_pkg::svt_cmd_t cmd
);

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_EXEC
	} state_t;

	state_t state_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.accept_off = 1'b1;
				cmd.clr_step   = !sts.cfg_take;
			end
			S_IDLE: begin
				if (sts.in_vld && !sts.cfg_take) begin
					cmd.scan_start = sts.in_query;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
			end
			S_EXEC: begin
				cmd.exec = sts.out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else if (sts.cfg_take) begin
			state_q <= S_CLEAR;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					if (sts.clr_last) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (sts.in_vld) begin
						state_q <= sts.in_query ? S_SCAN : S_EXEC;
					end
				end
				S_SCAN: begin
					if (sts.scan_done) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (sts.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

>>> rtl/core/svt_checker.sv
// Port-level checks for snapshot_version_tracker_core, attached by the bind below.
// Depends only on the top level's ports and the status codes in svt_pkg.
module svt_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [127:0] m_tdata,
	input logic [2:0]   m_tuser
);

	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// Only a successful request draws a version.
	a_ts_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != svt_pkg::ST_OK |-> m_tdata[63:0] == 64'd0)
		else $error("version drawn by a failed request");

	// A drawn version and a query minimum never come in the same item.
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[63:0] != 64'd0 |-> m_tdata[127:64] == 64'd0)
		else $error("timestamp and oldest_version both set");

	// Status codes stay within the defined set.
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser <= svt_pkg::ST_NOT_OWNER)
		else $error("undefined status code");

	// Only one request is held at a time, so the slave side closes after taking an item.
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item taken while one is held");

endmodule

bind snapshot_version_tracker_core svt_checker u_svt_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);
